[rtl/core/assert_macros.svh]
// Assertion macros shared by the sequencer RTL.
// Depends on nothing; the assertion bodies drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every rising clock edge, disabled while reset is high.
`define ASSERT_AT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check that an expression is never true outside reset.
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_AT(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

[rtl/core/ieas_pkg.sv]
// Types, codes and reset constants of the I2C EEPROM access sequencer.
// Depends on nothing; used by i2c_eeprom_access_sequencer_unit.
package ieas_pkg;

   localparam int ACTION_W   = 2;
   localparam int REQ_ADDR_W = 12;
   localparam int LENGTH_W   = 16;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [BYTE_W-1:0]   DEVICE_ADDRESS_RESET = 8'hA0;
   localparam logic [LENGTH_W-1:0] POLL_LIMIT_RESET     = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_LIMIT     = 1'b1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_DATA  = 2'd2,
      ACT_BUS   = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_START   = 4'd0,
      KIND_SEND    = 4'd1,
      KIND_RX_ACK  = 4'd2,
      KIND_RX_NACK = 4'd3,
      KIND_RESTART = 4'd4,
      KIND_STOP    = 4'd5,
      KIND_READ    = 4'd6,
      KIND_NEED    = 4'd7,
      KIND_DONE    = 4'd8,
      KIND_ERROR   = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_DEV   = 3'd1,
      PH_AHI   = 3'd2,
      PH_ALO   = 3'd3,
      PH_DEVR  = 3'd4,
      PH_RDATA = 3'd5,
      PH_NEED  = 3'd6,
      PH_WDATA = 3'd7
   } phase_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] bus_byte;
      logic [BYTE_W-1:0] host_byte;
   } rsp_type;

   function automatic rsp_type make_rsp(kind_type k, logic [BYTE_W-1:0] bo,
                                        logic [BYTE_W-1:0] hb);
      rsp_type r;
      r.kind      = k;
      r.bus_byte  = bo;
      r.host_byte = hb;
      return r;
   endfunction

endpackage

[rtl/core/i2c_eeprom_access_sequencer_unit.sv]
// I2C EEPROM access sequencer: turns host requests and bus completions into I2C primitives.
// Depends on ieas_pkg and assert_macros.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------------
//   req_    | in        | req_valid / req_stall  | action, address, length, data_byte,
//           |           |                        | bus_ack, bus_byte
//   rsp_    | out       | rsp_valid / rsp_stall  | kind, bus_byte_out, host_byte, last
//   csr_    | in        | csr_write              | csr_index, csr_data
//
// Each transaction is decoded combinationally against the state registers and its
// zero to three results land in a three-slot result buffer; one result leaves per cycle
// while rsp_stall is low. A new transaction is taken when the buffer is empty or its
// final result leaves in the same cycle, so one-result transactions run back to back and
// a transaction with k results holds the result port until all k have left.
// rsp_stall holds the buffer and therefore req_stall. Reset (synchronous) empties the
// buffer, returns the phase to idle and loads the register reset values.
// A new request's page offset is worked out through the ld1_ff and ld2_ff stages.
module i2c_eeprom_access_sequencer_unit #(
   parameter int PAGE_BYTES   = 32,
   parameter int ADDRESS_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ieas_pkg::ACTION_W-1:0]       req_action,
   input  logic [ieas_pkg::REQ_ADDR_W-1:0]     req_address,
   input  logic [ieas_pkg::LENGTH_W-1:0]       req_length,
   input  logic [ieas_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                req_bus_ack,
   input  logic [ieas_pkg::BYTE_W-1:0]         req_bus_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ieas_pkg::KIND_W-1:0]         rsp_kind,
   output logic [ieas_pkg::BYTE_W-1:0]         rsp_bus_byte_out,
   output logic [ieas_pkg::BYTE_W-1:0]         rsp_host_byte,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [ieas_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ieas_pkg::CSR_DATA_W-1:0]     csr_data
);

   `include "assert_macros.svh"

   localparam int AW  = ADDRESS_BITS;
   localparam int AW1 = ADDRESS_BITS + 1;
   localparam int PW  = $clog2(PAGE_BYTES);
   // Reciprocal for the page remainder: quotient estimate is low by at most one.
   localparam int RECIP = (2 ** ADDRESS_BITS) / PAGE_BYTES;
   localparam logic [AW-1:0]  RECIP_N   = AW'(RECIP);
   localparam logic [AW1-1:0] PAGE_W    = AW1'(PAGE_BYTES);
   localparam logic [PW-1:0]  PAGE_LAST = PW'(PAGE_BYTES - 1);

   // configuration registers
   logic [ieas_pkg::BYTE_W-1:0]   device_address_ff;
   logic [ieas_pkg::LENGTH_W-1:0] poll_limit_ff;

   // sequencing state
   ieas_pkg::phase_type           phase_ff, phase_in;
   logic                          is_write_ff, is_write_in;
   logic [AW-1:0]                 cur_addr_ff, cur_addr_in;
   logic [ieas_pkg::LENGTH_W-1:0] bytes_left_ff, bytes_left_in;
   logic [ieas_pkg::LENGTH_W-1:0] poll_count_ff, poll_count_in;
   logic [PW-1:0]                 page_off_ff, page_off_in;

   // page remainder pipeline
   logic                          ld1_ff, ld2_ff;
   logic [AW-1:0]                 quot_ff;
   logic [2*AW-1:0]               quot_prod;
   logic [AW1-1:0]                rem_raw, rem_fix;

   // result buffer
   ieas_pkg::rsp_type             slot_ff [3];
   ieas_pkg::rsp_type             slot_in [3];
   logic [1:0]                    cnt_ff, cnt_in;
   ieas_pkg::rsp_type             res [3];
   logic [1:0]                    n_res;

   logic                          req_accept, rsp_pop;
   ieas_pkg::action_type          act;
   logic                          is_request, addr_step;

   // shared decode terms
   logic [ieas_pkg::BYTE_W-1:0]   dev_w, dev_r, addr_hi, addr_lo;
   logic [AW+7:0]                 cur_wide;
   logic [AW+ieas_pkg::REQ_ADDR_W-1:0] req_wide;
   logic [ieas_pkg::LENGTH_W-1:0] poll_next, bytes_dec;
   logic                          poll_fail, bl_zero, bl_one, bl_two, page_end;

   assign act        = ieas_pkg::action_type'(req_action);
   assign rsp_pop    = rsp_valid && !rsp_stall;
   // take a transaction only if the buffer will be empty after this cycle
   assign req_stall  = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_pop));
   assign req_accept = req_valid && !req_stall;

   assign dev_w     = {device_address_ff[7:1], 1'b0};
   assign dev_r     = {device_address_ff[7:1], 1'b1};
   assign cur_wide  = {8'h00, cur_addr_ff};
   assign addr_hi   = cur_wide[15:8];
   assign addr_lo   = cur_addr_ff[7:0];
   assign req_wide  = {AW'(0), req_address};
   assign poll_next = poll_count_ff + 16'd1;
   assign poll_fail = (poll_next >= poll_limit_ff) || (poll_next == 16'd0);
   assign bytes_dec = bytes_left_ff - 16'd1;
   assign bl_zero   = (bytes_left_ff == 16'd0);
   assign bl_one    = (bytes_left_ff == 16'd1);
   assign bl_two    = (bytes_left_ff == 16'd2);
   // next address crosses a page when the offset tops out or the address wraps
   assign page_end  = (page_off_ff == PAGE_LAST) || (&cur_addr_ff);

   assign is_request = (act == ieas_pkg::ACT_READ) || (act == ieas_pkg::ACT_WRITE);
   // the address advances on a read byte and on an acknowledged write byte
   assign addr_step  = req_accept && (act == ieas_pkg::ACT_BUS) &&
                       ((phase_ff == ieas_pkg::PH_RDATA) ||
                        ((phase_ff == ieas_pkg::PH_WDATA) && !req_bus_ack));

   // ---------------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= ieas_pkg::DEVICE_ADDRESS_RESET;
         poll_limit_ff     <= ieas_pkg::POLL_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ieas_pkg::CSR_DEVICE_ADDRESS: device_address_ff <= csr_data[7:0];
            ieas_pkg::CSR_POLL_LIMIT:     poll_limit_ff     <= csr_data;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Result list of the transaction being taken
   // ---------------------------------------------------------------------------
   always_comb begin
      res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_STOP, 8'h00, 8'h00);
      res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_ERROR, 8'h00, 8'h00);
      res[2] = ieas_pkg::make_rsp(ieas_pkg::KIND_ERROR, 8'h00, 8'h00);
      n_res  = 2'd0;
      unique case (act)
         ieas_pkg::ACT_READ, ieas_pkg::ACT_WRITE: begin
            if (phase_ff == ieas_pkg::PH_IDLE) begin
               res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_START, 8'h00, 8'h00);
               res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_SEND, dev_w, 8'h00);
               n_res  = 2'd2;
            end
         end
         ieas_pkg::ACT_DATA: begin
            if (phase_ff == ieas_pkg::PH_NEED) begin
               res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_SEND, req_data_byte, 8'h00);
               n_res  = 2'd1;
            end
         end
         ieas_pkg::ACT_BUS: begin
            unique case (phase_ff)
               ieas_pkg::PH_DEV: begin
                  if (req_bus_ack) begin
                     // stop first; a write poll may retry, anything else fails
                     if (is_write_ff && !poll_fail) begin
                        res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_START, 8'h00, 8'h00);
                        res[2] = ieas_pkg::make_rsp(ieas_pkg::KIND_SEND, dev_w, 8'h00);
                        n_res  = 2'd3;
                     end else begin
                        n_res  = 2'd2;
                     end
                  end else if (is_write_ff && bl_zero) begin
                     res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_DONE, 8'h00, 8'h00);
                     n_res  = 2'd2;
                  end else begin
                     res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_SEND, addr_hi, 8'h00);
                     n_res  = 2'd1;
                  end
               end
               ieas_pkg::PH_AHI: begin
                  if (req_bus_ack) begin
                     n_res  = 2'd2;
                  end else begin
                     res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_SEND, addr_lo, 8'h00);
                     n_res  = 2'd1;
                  end
               end
               ieas_pkg::PH_ALO: begin
                  if (req_bus_ack) begin
                     n_res  = 2'd2;
                  end else if (is_write_ff) begin
                     res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_NEED, 8'h00, 8'h00);
                     n_res  = 2'd1;
                  end else begin
                     res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_RESTART, 8'h00, 8'h00);
                     res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_SEND, dev_r, 8'h00);
                     n_res  = 2'd2;
                  end
               end
               ieas_pkg::PH_DEVR: begin
                  if (req_bus_ack) begin
                     n_res  = 2'd2;
                  end else if (bl_zero) begin
                     res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_DONE, 8'h00, 8'h00);
                     n_res  = 2'd2;
                  end else begin
                     res[0] = ieas_pkg::make_rsp(bl_one ? ieas_pkg::KIND_RX_NACK
                                                        : ieas_pkg::KIND_RX_ACK,
                                                 8'h00, 8'h00);
                     n_res  = 2'd1;
                  end
               end
               ieas_pkg::PH_RDATA: begin
                  res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_READ, 8'h00, req_bus_byte);
                  if (bl_one) begin
                     res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_STOP, 8'h00, 8'h00);
                     res[2] = ieas_pkg::make_rsp(ieas_pkg::KIND_DONE, 8'h00, 8'h00);
                     n_res  = 2'd3;
                  end else begin
                     res[1] = ieas_pkg::make_rsp(bl_two ? ieas_pkg::KIND_RX_NACK
                                                        : ieas_pkg::KIND_RX_ACK,
                                                 8'h00, 8'h00);
                     n_res  = 2'd2;
                  end
               end
               ieas_pkg::PH_WDATA: begin
                  if (req_bus_ack) begin
                     n_res  = 2'd2;
                  end else if (bl_one || page_end) begin
                     res[1] = ieas_pkg::make_rsp(ieas_pkg::KIND_START, 8'h00, 8'h00);
                     res[2] = ieas_pkg::make_rsp(ieas_pkg::KIND_SEND, dev_w, 8'h00);
                     n_res  = 2'd3;
                  end else begin
                     res[0] = ieas_pkg::make_rsp(ieas_pkg::KIND_NEED, 8'h00, 8'h00);
                     n_res  = 2'd1;
                  end
               end
               ieas_pkg::PH_IDLE, ieas_pkg::PH_NEED: begin
                  n_res = 2'd0;
               end
            endcase
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Next state of the sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      is_write_in   = is_write_ff;
      cur_addr_in   = cur_addr_ff;
      bytes_left_in = bytes_left_ff;
      poll_count_in = poll_count_ff;
      if (req_accept) begin
         unique case (act)
            ieas_pkg::ACT_READ, ieas_pkg::ACT_WRITE: begin
               if (phase_ff == ieas_pkg::PH_IDLE) begin
                  phase_in      = ieas_pkg::PH_DEV;
                  is_write_in   = (act == ieas_pkg::ACT_WRITE);
                  cur_addr_in   = req_wide[AW-1:0];
                  bytes_left_in = req_length;
                  poll_count_in = 16'd0;
               end
            end
            ieas_pkg::ACT_DATA: begin
               if (phase_ff == ieas_pkg::PH_NEED) begin
                  phase_in = ieas_pkg::PH_WDATA;
               end
            end
            ieas_pkg::ACT_BUS: begin
               unique case (phase_ff)
                  ieas_pkg::PH_DEV: begin
                     if (is_write_ff && req_bus_ack) begin
                        poll_count_in = poll_next;
                        phase_in      = poll_fail ? ieas_pkg::PH_IDLE : ieas_pkg::PH_DEV;
                     end else if (req_bus_ack) begin
                        phase_in = ieas_pkg::PH_IDLE;
                     end else begin
                        if (is_write_ff) begin
                           poll_count_in = 16'd0;
                        end
                        phase_in = (is_write_ff && bl_zero) ? ieas_pkg::PH_IDLE
                                                            : ieas_pkg::PH_AHI;
                     end
                  end
                  ieas_pkg::PH_AHI: begin
                     phase_in = req_bus_ack ? ieas_pkg::PH_IDLE : ieas_pkg::PH_ALO;
                  end
                  ieas_pkg::PH_ALO: begin
                     priority if (req_bus_ack) begin
                        phase_in = ieas_pkg::PH_IDLE;
                     end else if (is_write_ff) begin
                        phase_in = ieas_pkg::PH_NEED;
                     end else begin
                        phase_in = ieas_pkg::PH_DEVR;
                     end
                  end
                  ieas_pkg::PH_DEVR: begin
                     phase_in = (req_bus_ack || bl_zero) ? ieas_pkg::PH_IDLE
                                                         : ieas_pkg::PH_RDATA;
                  end
                  ieas_pkg::PH_RDATA: begin
                     cur_addr_in   = cur_addr_ff + AW'(1);
                     bytes_left_in = bytes_dec;
                     phase_in      = bl_one ? ieas_pkg::PH_IDLE : ieas_pkg::PH_RDATA;
                  end
                  ieas_pkg::PH_WDATA: begin
                     if (req_bus_ack) begin
                        phase_in = ieas_pkg::PH_IDLE;
                     end else begin
                        cur_addr_in   = cur_addr_ff + AW'(1);
                        bytes_left_in = bytes_dec;
                        if (bl_one || page_end) begin
                           poll_count_in = 16'd0;
                           phase_in      = ieas_pkg::PH_DEV;
                        end else begin
                           phase_in = ieas_pkg::PH_NEED;
                        end
                     end
                  end
                  ieas_pkg::PH_IDLE, ieas_pkg::PH_NEED: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Page offset: remainder of the start address, then count with the address
   // ---------------------------------------------------------------------------
   assign quot_prod = {AW'(0), cur_addr_ff} * {AW'(0), RECIP_N};
   assign rem_raw   = {1'b0, cur_addr_ff} - ({1'b0, quot_ff} * PAGE_W);
   assign rem_fix   = (rem_raw >= PAGE_W) ? (rem_raw - PAGE_W) : rem_raw;

   always_comb begin
      page_off_in = page_off_ff;
      if (ld2_ff) begin
         page_off_in = rem_fix[PW-1:0];
      end else if (addr_step) begin
         page_off_in = page_end ? PW'(0) : (page_off_ff + PW'(1));
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_prod[2*AW-1:AW];
      if (reset) begin
         ld1_ff <= 1'b0;
         ld2_ff <= 1'b0;
      end else begin
         // start address sits in cur_addr_ff while ld1_ff and ld2_ff carry the load
         ld1_ff <= req_accept && is_request && (phase_ff == ieas_pkg::PH_IDLE);
         ld2_ff <= ld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= ieas_pkg::PH_IDLE;
         is_write_ff   <= 1'b0;
         cur_addr_ff   <= '0;
         bytes_left_ff <= '0;
         poll_count_ff <= '0;
         page_off_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         is_write_ff   <= is_write_in;
         cur_addr_ff   <= cur_addr_in;
         bytes_left_ff <= bytes_left_in;
         poll_count_ff <= poll_count_in;
         page_off_ff   <= page_off_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Result buffer: load a whole transaction's results, drain from slot 0
   // ---------------------------------------------------------------------------
   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (req_accept) begin
         slot_in = res;
         cnt_in  = n_res;
      end else if (rsp_pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_valid        = (cnt_ff != 2'd0);
   assign rsp_kind         = slot_ff[0].kind;
   assign rsp_bus_byte_out = slot_ff[0].bus_byte;
   assign rsp_host_byte    = slot_ff[0].host_byte;
   assign rsp_last         = (cnt_ff == 2'd1);

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `ASSERT_AT(a_need_is_write, clock, reset, (phase_ff == ieas_pkg::PH_NEED || phase_ff == ieas_pkg::PH_WDATA) |-> is_write_ff)
   `ASSERT_AT(a_rdata_has_bytes, clock, reset, (phase_ff == ieas_pkg::PH_RDATA) |-> (!is_write_ff && !bl_zero))
   `ASSERT_AT(a_idle_ends_clean, clock, reset, (rsp_last && phase_ff == ieas_pkg::PH_IDLE) |-> (rsp_kind == ieas_pkg::KIND_DONE || rsp_kind == ieas_pkg::KIND_ERROR))
   `ASSERT_AT(a_pop_drains, clock, reset, (rsp_pop && !req_accept) |=> (cnt_ff == $past(cnt_ff) - 2'd1))

endmodule

[dv/tb.sv]
// Self-checking testbench for i2c_eeprom_access_sequencer_unit.
// Depends on ieas_pkg and the sequencer RTL. It drives requests, bus completions and register
// writes, predicts the primitive stream, and checks every result against that prediction.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_BYTES = 32;

   typedef struct packed {
      ieas_pkg::kind_type          kind;
      logic [ieas_pkg::BYTE_W-1:0] bus_byte;
      logic [ieas_pkg::BYTE_W-1:0] host_byte;
      logic                        last;
   } primitive_type;

   typedef struct packed {
      ieas_pkg::action_type            act;
      logic [ieas_pkg::REQ_ADDR_W-1:0] addr;
      logic [ieas_pkg::LENGTH_W-1:0]   len;
      logic [ieas_pkg::BYTE_W-1:0]     data;
      logic                            ack;
      logic [ieas_pkg::BYTE_W-1:0]     rx;
   } req_item_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [ieas_pkg::ACTION_W-1:0]   req_action;
   logic [ieas_pkg::REQ_ADDR_W-1:0] req_address;
   logic [ieas_pkg::LENGTH_W-1:0]   req_length;
   logic [ieas_pkg::BYTE_W-1:0]     req_data_byte;
   logic                            req_bus_ack;
   logic [ieas_pkg::BYTE_W-1:0]     req_bus_byte;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [ieas_pkg::KIND_W-1:0]     rsp_kind;
   logic [ieas_pkg::BYTE_W-1:0]     rsp_bus_byte_out;
   logic [ieas_pkg::BYTE_W-1:0]     rsp_host_byte;
   logic                            rsp_last;
   logic                            csr_write;
   logic [ieas_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ieas_pkg::CSR_DATA_W-1:0] csr_data;

   // Predicted sequencer state and register copies.
   ieas_pkg::phase_type             seq_phase;
   logic                            seq_write;
   logic [ieas_pkg::REQ_ADDR_W-1:0] seq_addr;
   logic [ieas_pkg::LENGTH_W-1:0]   seq_left;
   logic [ieas_pkg::LENGTH_W-1:0]   seq_polls;
   logic [ieas_pkg::BYTE_W-1:0]     dev_reg;
   logic [ieas_pkg::LENGTH_W-1:0]   poll_lim;

   primitive_type step_primitives[$];
   primitive_type pending_primitives[$];

   int  mismatch_count;
   int  productive_items;
   // When set, neither side inserts idle cycles.
   bit  full_rate;

   i2c_eeprom_access_sequencer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_address      (req_address),
      .req_length       (req_length),
      .req_data_byte    (req_data_byte),
      .req_bus_ack      (req_bus_ack),
      .req_bus_byte     (req_bus_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_bus_byte_out (rsp_bus_byte_out),
      .rsp_host_byte    (rsp_host_byte),
      .rsp_last         (rsp_last),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Primitive predictor
   // ---------------------------------------------------------------------------------------

   function automatic void emit_primitive(ieas_pkg::kind_type k,
                                          logic [ieas_pkg::BYTE_W-1:0] bo,
                                          logic [ieas_pkg::BYTE_W-1:0] hb);
      primitive_type p;
      p.kind      = k;
      p.bus_byte  = bo;
      p.host_byte = hb;
      p.last      = 1'b0;
      step_primitives.push_back(p);
   endfunction

   // Open a new poll: start, then the device byte in write form.
   function automatic void start_poll();
      emit_primitive(ieas_pkg::KIND_START, '0, '0);
      emit_primitive(ieas_pkg::KIND_SEND, dev_reg & 8'hFE, '0);
      seq_phase = ieas_pkg::PH_DEV;
   endfunction

   // Close the bus and finish with done or error.
   function automatic void stop_with(ieas_pkg::kind_type k);
      emit_primitive(ieas_pkg::KIND_STOP, '0, '0);
      emit_primitive(k, '0, '0);
      seq_phase = ieas_pkg::PH_IDLE;
   endfunction

   // The final byte of a read is received with NACK, all others with ACK.
   function automatic void ask_receive();
      seq_phase = ieas_pkg::PH_RDATA;
      emit_primitive(seq_left == 1 ? ieas_pkg::KIND_RX_NACK : ieas_pkg::KIND_RX_ACK, '0, '0);
   endfunction

   function automatic void send_addr_high();
      seq_phase = ieas_pkg::PH_AHI;
      emit_primitive(ieas_pkg::KIND_SEND, 8'(seq_addr >> 8), '0);
   endfunction

   function automatic void on_bus_done(logic nack, logic [ieas_pkg::BYTE_W-1:0] rx);
      case (seq_phase)
         ieas_pkg::PH_DEV: begin
            if (seq_write) begin
               if (nack) begin
                  // Busy poll: retry until the limit runs out.
                  emit_primitive(ieas_pkg::KIND_STOP, '0, '0);
                  seq_polls = seq_polls + 16'd1;
                  if (seq_polls >= poll_lim || seq_polls == 0) begin
                     emit_primitive(ieas_pkg::KIND_ERROR, '0, '0);
                     seq_phase = ieas_pkg::PH_IDLE;
                  end else begin
                     start_poll();
                  end
               end else begin
                  seq_polls = '0;
                  if (seq_left == 0) stop_with(ieas_pkg::KIND_DONE);
                  else send_addr_high();
               end
            end else if (nack) begin
               stop_with(ieas_pkg::KIND_ERROR);
            end else begin
               send_addr_high();
            end
         end
         ieas_pkg::PH_AHI: begin
            if (nack) stop_with(ieas_pkg::KIND_ERROR);
            else begin
               seq_phase = ieas_pkg::PH_ALO;
               emit_primitive(ieas_pkg::KIND_SEND, seq_addr[7:0], '0);
            end
         end
         ieas_pkg::PH_ALO: begin
            if (nack) stop_with(ieas_pkg::KIND_ERROR);
            else if (seq_write) begin
               seq_phase = ieas_pkg::PH_NEED;
               emit_primitive(ieas_pkg::KIND_NEED, '0, '0);
            end else begin
               emit_primitive(ieas_pkg::KIND_RESTART, '0, '0);
               seq_phase = ieas_pkg::PH_DEVR;
               emit_primitive(ieas_pkg::KIND_SEND, dev_reg | 8'h01, '0);
            end
         end
         ieas_pkg::PH_DEVR: begin
            if (nack) stop_with(ieas_pkg::KIND_ERROR);
            else if (seq_left == 0) stop_with(ieas_pkg::KIND_DONE);
            else ask_receive();
         end
         ieas_pkg::PH_RDATA: begin
            // The acknowledge bit means nothing after a receive.
            emit_primitive(ieas_pkg::KIND_READ, '0, rx);
            seq_addr = seq_addr + 12'd1;
            seq_left = seq_left - 16'd1;
            if (seq_left == 0) stop_with(ieas_pkg::KIND_DONE);
            else ask_receive();
         end
         ieas_pkg::PH_WDATA: begin
            if (nack) stop_with(ieas_pkg::KIND_ERROR);
            else begin
               seq_addr = seq_addr + 12'd1;
               seq_left = seq_left - 16'd1;
               // Page end or final byte: stop and poll until the write cycle is over.
               if (seq_left == 0 || (seq_addr % PAGE_BYTES) == 0) begin
                  emit_primitive(ieas_pkg::KIND_STOP, '0, '0);
                  seq_polls = '0;
                  start_poll();
               end else begin
                  seq_phase = ieas_pkg::PH_NEED;
                  emit_primitive(ieas_pkg::KIND_NEED, '0, '0);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Advance the predicted state by one accepted transaction; queue what it causes.
   function automatic int predict_primitives(req_item_type it);
      primitive_type p;
      int            n;
      step_primitives.delete();
      case (it.act)
         ieas_pkg::ACT_READ, ieas_pkg::ACT_WRITE: begin
            if (seq_phase == ieas_pkg::PH_IDLE) begin
               seq_write = (it.act == ieas_pkg::ACT_WRITE);
               seq_addr  = it.addr;
               seq_left  = it.len;
               seq_polls = '0;
               start_poll();
            end
         end
         ieas_pkg::ACT_DATA: begin
            if (seq_phase == ieas_pkg::PH_NEED) begin
               seq_phase = ieas_pkg::PH_WDATA;
               emit_primitive(ieas_pkg::KIND_SEND, it.data, '0);
            end
         end
         default: on_bus_done(it.ack, it.rx);
      endcase
      n = step_primitives.size();
      for (int i = 0; i < n; i++) begin
         p      = step_primitives[i];
         p.last = (i == n - 1);
         pending_primitives.push_back(p);
      end
      return n;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------

   function automatic req_item_type random_item(ieas_pkg::action_type a);
      req_item_type it;
      it.act  = a;
      it.addr = 12'($urandom);
      it.len  = 16'($urandom);
      it.data = 8'($urandom);
      it.ack  = 1'($urandom);
      it.rx   = 8'($urandom);
      return it;
   endfunction

   // Pick a transaction that the sequencer must drop in its present phase.
   function automatic req_item_type ignored_item();
      bit                   coin;
      ieas_pkg::action_type req_act;
      coin    = 1'($urandom_range(0, 1));
      req_act = $urandom_range(0, 1) ? ieas_pkg::ACT_WRITE : ieas_pkg::ACT_READ;
      if (seq_phase == ieas_pkg::PH_NEED)
         return random_item(coin ? ieas_pkg::ACT_BUS : req_act);
      else if (seq_phase == ieas_pkg::PH_IDLE)
         return random_item(coin ? ieas_pkg::ACT_BUS : ieas_pkg::ACT_DATA);
      else
         return random_item(coin ? ieas_pkg::ACT_DATA : req_act);
   endfunction

   // Present one transaction after a random gap; hold it until accepted, then predict.
   task automatic send_item(req_item_type it);
      int gap;
      gap = full_rate ? 0 : $urandom_range(0, 17);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= it.act;
      req_address   <= it.addr;
      req_length    <= it.len;
      req_data_byte <= it.data;
      req_bus_ack   <= it.ack;
      req_bus_byte  <= it.rx;
      do @(posedge clock); while (req_stall);
      if (predict_primitives(it) > 0) productive_items++;
   endtask

   task automatic send_request(ieas_pkg::action_type a,
                               logic [ieas_pkg::REQ_ADDR_W-1:0] addr,
                               logic [ieas_pkg::LENGTH_W-1:0] len);
      req_item_type it;
      it      = random_item(a);
      it.addr = addr;
      it.len  = len;
      send_item(it);
   endtask

   task automatic send_completion(logic nack, logic [ieas_pkg::BYTE_W-1:0] rx);
      req_item_type it;
      it     = random_item(ieas_pkg::ACT_BUS);
      it.ack = nack;
      it.rx  = rx;
      send_item(it);
   endtask

   task automatic send_data(logic [ieas_pkg::BYTE_W-1:0] b);
      req_item_type it;
      it      = random_item(ieas_pkg::ACT_DATA);
      it.data = b;
      send_item(it);
   endtask

   // Drop valid and hold off until every predicted result is in, then let the block settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_primitives.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [ieas_pkg::CSR_IDX_W-1:0] idx,
                            logic [ieas_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == ieas_pkg::CSR_DEVICE_ADDRESS) dev_reg = val[ieas_pkg::BYTE_W-1:0];
      else poll_lim = val;
   endtask

   // Play the bus agent and the host for one request until the sequencer goes idle.
   // Polls are NACKed at poll_pct, other sends at nack_pct; from step abort_after on
   // (when nonzero) every send that can fail is NACKed, which cuts long transfers short.
   task automatic run_transfer(ieas_pkg::action_type a, logic [ieas_pkg::REQ_ADDR_W-1:0] addr,
                               logic [ieas_pkg::LENGTH_W-1:0] len, int poll_pct,
                               int nack_pct, int abort_after, int noise_pct);
      req_item_type it;
      int           steps;
      send_request(a, addr, len);
      steps = 1;
      while (seq_phase != ieas_pkg::PH_IDLE) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            send_item(ignored_item());
         end else begin
            if (seq_phase == ieas_pkg::PH_NEED) begin
               it = random_item(ieas_pkg::ACT_DATA);
            end else begin
               it = random_item(ieas_pkg::ACT_BUS);
               if (seq_phase == ieas_pkg::PH_DEV && seq_write)
                  it.ack = ($urandom_range(0, 99) < poll_pct);
               else if (seq_phase != ieas_pkg::PH_RDATA)
                  it.ack = (abort_after > 0 && steps >= abort_after) ||
                           ($urandom_range(0, 99) < nack_pct);
            end
            send_item(it);
            steps++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // One-byte read at the top address, with stray traffic in idle and while busy.
   task automatic test_read_extremes();
      send_completion(1'b1, 8'hFF);
      send_data(8'hFF);
      send_request(ieas_pkg::ACT_READ, 12'hFFF, 16'd1);
      send_request(ieas_pkg::ACT_WRITE, 12'h000, 16'hFFFF);
      send_data(8'h00);
      send_completion(1'b0, 8'h00);
      send_completion(1'b0, 8'h00);
      send_completion(1'b0, 8'h00);
      send_completion(1'b0, 8'h00);
      // Receive with the acknowledge bit set: it must be ignored.
      send_completion(1'b1, 8'hFF);
   endtask

   task automatic test_zero_length();
      send_request(ieas_pkg::ACT_READ, 12'h000, 16'd0);
      repeat (4) send_completion(1'b0, 8'h00);
      send_request(ieas_pkg::ACT_WRITE, 12'h0A5, 16'd0);
      send_completion(1'b0, 8'h00);
   endtask

   task automatic test_nack_errors();
      send_request(ieas_pkg::ACT_READ, 12'h5A5, 16'hFFFF);
      send_completion(1'b1, 8'h00);
      send_request(ieas_pkg::ACT_WRITE, 12'hA5A, 16'hFFFF);
      repeat (3) send_completion(1'b0, 8'h00);
      // Completion while waiting for data is dropped.
      send_completion(1'b0, 8'h00);
      send_data(8'h5A);
      send_completion(1'b1, 8'h00);
   endtask

   task automatic test_poll_limit();
      wait_drained();
      write_reg(ieas_pkg::CSR_POLL_LIMIT, 16'd1);
      send_request(ieas_pkg::ACT_WRITE, 12'h800, 16'd3);
      send_completion(1'b1, 8'h00);
      wait_drained();
      write_reg(ieas_pkg::CSR_POLL_LIMIT, 16'hFFFF);
   endtask

   // Mostly well-formed transfers with random content under one register setting.
   task automatic test_random_traffic(logic [ieas_pkg::BYTE_W-1:0] dev,
                                      logic [ieas_pkg::LENGTH_W-1:0] limit, int quota);
      int                              target;
      int                              abort_after;
      ieas_pkg::action_type            a;
      logic [ieas_pkg::REQ_ADDR_W-1:0] addr;
      logic [ieas_pkg::LENGTH_W-1:0]   len;
      wait_drained();
      write_reg(ieas_pkg::CSR_DEVICE_ADDRESS, {8'h00, dev});
      write_reg(ieas_pkg::CSR_POLL_LIMIT, limit);
      target = productive_items + quota;
      while (productive_items < target) begin
         full_rate = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) send_item(ignored_item());
         if ($urandom_range(0, 9) == 0) wait_drained();
         a = $urandom_range(0, 1) ? ieas_pkg::ACT_WRITE : ieas_pkg::ACT_READ;
         case ($urandom_range(0, 3))
            0:       addr = {7'h7F, 5'($urandom_range(0, 31))};
            1:       addr = {7'($urandom), 5'($urandom_range(26, 31))};
            default: addr = 12'($urandom);
         endcase
         // Keep most transfers short; long ones are cut off by a NACK early on.
         if ($urandom_range(0, 7) == 0) begin
            len         = 16'($urandom);
            abort_after = $urandom_range(1, 4);
         end else begin
            len         = 16'($urandom_range(0, 18));
            abort_after = 0;
         end
         run_transfer(a, addr, len, 30, 3, abort_after, 8);
      end
      full_rate = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Result checking and back-pressure
   // ---------------------------------------------------------------------------------------

   function automatic void flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   initial begin : rsp_check
      primitive_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_primitives.size() == 0) begin
               flag_mismatch($sformatf("unexpected result: kind %0d bus %02h host %02h last %0b",
                                       rsp_kind, rsp_bus_byte_out, rsp_host_byte, rsp_last));
            end else begin
               want = pending_primitives.pop_front();
               if (rsp_kind !== want.kind || rsp_bus_byte_out !== want.bus_byte ||
                   rsp_host_byte !== want.host_byte || rsp_last !== want.last)
                  flag_mismatch($sformatf(
                     "mismatch: expected kind %0d bus %02h host %02h last %0b, got %0d %02h %02h %0b",
                     want.kind, want.bus_byte, want.host_byte, want.last,
                     rsp_kind, rsp_bus_byte_out, rsp_host_byte, rsp_last));
            end
         end
      end
   end

   // Stall the result port for a random number of cycles before each result.
   initial begin : rsp_backpressure
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = full_rate ? 0 : $urandom_range(0, 17);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = ieas_pkg::ACT_READ;
      req_address      = '0;
      req_length       = '0;
      req_data_byte    = '0;
      req_bus_ack      = 1'b0;
      req_bus_byte     = '0;
      csr_write        = 1'b0;
      csr_index        = ieas_pkg::CSR_DEVICE_ADDRESS;
      csr_data         = '0;
      seq_phase        = ieas_pkg::PH_IDLE;
      seq_write        = 1'b0;
      seq_addr         = '0;
      seq_left         = '0;
      seq_polls        = '0;
      dev_reg          = ieas_pkg::DEVICE_ADDRESS_RESET;
      poll_lim         = ieas_pkg::POLL_LIMIT_RESET;
      mismatch_count   = 0;
      productive_items = 0;
      full_rate        = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_read_extremes();
      test_zero_length();
      test_nack_errors();
      test_poll_limit();
      test_random_traffic(8'h00, 16'd1, 75);
      test_random_traffic(8'hFE, 16'hFFFF, 75);
      test_random_traffic(8'hA1, 16'd3, 75);
      test_random_traffic(8'($urandom_range(0, 254)), 16'($urandom_range(1, 6)), 75);
      test_random_traffic(ieas_pkg::DEVICE_ADDRESS_RESET, 16'd2, 75);

      wait_drained();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && pending_primitives.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ieas_pkg.sv
rtl/core/i2c_eeprom_access_sequencer_unit.sv
dv/tb.sv
